### hdl/bdl_pkg.sv
`default_nettype none

package bdl_pkg;

	localparam int DEPTH   = 16;
	localparam int DATA_W  = 8;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	localparam int REQ_W   = 3;
	localparam int VAL_W   = 8;
	localparam int POS_W   = 4;
	localparam int COUNT_W = 5;
	localparam int STAT_W  = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_INS_FRONT,
		REQ_INS_BACK,
		REQ_RM_FRONT,
		REQ_RM_BACK,
		REQ_RM_POS,
		REQ_RM_VALUE,
		REQ_SEARCH,
		REQ_PEEK
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK,
		ST_EMPTY,
		ST_FULL,
		ST_NOT_FOUND,
		ST_BAD_POS
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_TAKE,
		S_SHDN,
		S_SHUP,
		S_WR0,
		S_PEEK,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		RD_START,
		RD_NEXT,
		RD_PREV
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_BACK,
		WR_DOWN,
		WR_UP,
		WR_FRONT
	} wr_sel_t;

	typedef enum logic [1:0] {
		PTR_HOLD,
		PTR_START,
		PTR_INC,
		PTR_DEC
	} ptr_sel_t;

	typedef struct packed {
		logic     start;
		rd_sel_t  rd_sel;
		wr_sel_t  wr_sel;
		ptr_sel_t ptr_sel;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     cap_val;
		logic     cap_pos;
		logic     st_we;
		status_t  st_code;
		logic     load_out;
	} ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic pos_bad;
		logic hit;
		logic last;
		logic ptr_zero;
	} flags_t;

endpackage

`default_nettype wire

### hdl/bdl_if.sv
`default_nettype none

interface bdl_req_if;
	logic                      valid;
	logic                      ready;
	logic [bdl_pkg::REQ_W-1:0] req_type;
	logic [bdl_pkg::VAL_W-1:0] value;
	logic [bdl_pkg::POS_W-1:0] position;

	modport source (output valid, output req_type, output value, output position, input ready);
	modport sink (input valid, input req_type, input value, input position, output ready);
endinterface

interface bdl_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [bdl_pkg::VAL_W-1:0]   result_value;
	logic [bdl_pkg::POS_W-1:0]   found_position;
	logic [bdl_pkg::COUNT_W-1:0] entry_count;
	logic [bdl_pkg::STAT_W-1:0]  status;

	modport source (output valid, output result_value, output found_position,
		output entry_count, output status, input ready);
	modport sink (input valid, input result_value, input found_position,
		input entry_count, input status, output ready);
endinterface

`default_nettype wire

### hdl/bdl_ctrl.sv
`default_nettype none

module bdl_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  bdl_pkg::req_t        in_req,
	input  wire logic            out_ready,
	input  bdl_pkg::flags_t      flags,
	output bdl_pkg::ctrl_t       ctrl,
	output logic                 in_ready,
	output logic                 out_valid
);

	bdl_pkg::state_t state_q;
	bdl_pkg::state_t state_d;
	bdl_pkg::req_t   req_q;
	logic            out_valid_q;
	logic            out_free;
	logic            start;

	assign in_ready  = (state_q == bdl_pkg::S_IDLE);
	assign start     = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bdl_pkg::S_IDLE: begin
				if (in_valid) begin
					case (in_req)
						bdl_pkg::REQ_INS_FRONT: begin
							if (flags.full)
								state_d = bdl_pkg::S_FIN;
							else if (flags.empty)
								state_d = bdl_pkg::S_WR0;
							else
								state_d = bdl_pkg::S_SHUP;
						end
						bdl_pkg::REQ_INS_BACK: state_d = bdl_pkg::S_FIN;
						default: begin
							if (flags.empty)
								state_d = bdl_pkg::S_FIN;
							else if (in_req inside {bdl_pkg::REQ_RM_FRONT, bdl_pkg::REQ_RM_BACK})
								state_d = bdl_pkg::S_TAKE;
							else if (in_req == bdl_pkg::REQ_RM_POS)
								state_d = flags.pos_bad ? bdl_pkg::S_FIN : bdl_pkg::S_TAKE;
							else if (in_req == bdl_pkg::REQ_PEEK)
								state_d = bdl_pkg::S_PEEK;
							else
								state_d = bdl_pkg::S_SCAN;
						end
					endcase
				end
			end
			bdl_pkg::S_SCAN: begin
				if (flags.hit) begin
					if (req_q == bdl_pkg::REQ_RM_VALUE && !flags.last)
						state_d = bdl_pkg::S_SHDN;
					else
						state_d = bdl_pkg::S_FIN;
				end else if (flags.last) begin
					state_d = bdl_pkg::S_FIN;
				end
			end
			bdl_pkg::S_TAKE: state_d = flags.last ? bdl_pkg::S_FIN : bdl_pkg::S_SHDN;
			bdl_pkg::S_SHDN: begin
				if (flags.last)
					state_d = bdl_pkg::S_FIN;
			end
			bdl_pkg::S_SHUP: begin
				if (flags.ptr_zero)
					state_d = bdl_pkg::S_WR0;
			end
			bdl_pkg::S_WR0:  state_d = bdl_pkg::S_FIN;
			bdl_pkg::S_PEEK: state_d = bdl_pkg::S_FIN;
			bdl_pkg::S_FIN: begin
				if (out_free)
					state_d = bdl_pkg::S_IDLE;
			end
			default: state_d = bdl_pkg::S_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		ctrl          = '0;
		ctrl.start    = start;
		ctrl.rd_sel   = bdl_pkg::RD_NEXT;
		ctrl.wr_sel   = bdl_pkg::WR_NONE;
		ctrl.ptr_sel  = bdl_pkg::PTR_HOLD;
		ctrl.st_code  = bdl_pkg::ST_OK;
		case (state_q)
			bdl_pkg::S_IDLE: begin
				ctrl.rd_sel  = bdl_pkg::RD_START;
				ctrl.ptr_sel = bdl_pkg::PTR_START;
				if (in_valid) begin
					case (in_req)
						bdl_pkg::REQ_INS_FRONT: begin
							ctrl.st_we   = flags.full;
							ctrl.st_code = bdl_pkg::ST_FULL;
						end
						bdl_pkg::REQ_INS_BACK: begin
							ctrl.st_we   = flags.full;
							ctrl.st_code = bdl_pkg::ST_FULL;
							if (!flags.full) begin
								ctrl.wr_sel  = bdl_pkg::WR_BACK;
								ctrl.cnt_inc = 1'b1;
							end
						end
						default: begin
							if (flags.empty) begin
								ctrl.st_we   = 1'b1;
								ctrl.st_code = (in_req == bdl_pkg::REQ_SEARCH) ?
									bdl_pkg::ST_NOT_FOUND : bdl_pkg::ST_EMPTY;
							end else if (in_req == bdl_pkg::REQ_RM_POS && flags.pos_bad) begin
								ctrl.st_we   = 1'b1;
								ctrl.st_code = bdl_pkg::ST_BAD_POS;
							end
						end
					endcase
				end
			end
			bdl_pkg::S_SCAN: begin
				ctrl.ptr_sel = bdl_pkg::PTR_INC;
				if (flags.hit) begin
					ctrl.cap_pos = 1'b1;
					if (req_q == bdl_pkg::REQ_RM_VALUE) begin
						ctrl.cap_val = 1'b1;
						ctrl.cnt_dec = flags.last;
					end
				end else if (flags.last) begin
					ctrl.st_we   = 1'b1;
					ctrl.st_code = bdl_pkg::ST_NOT_FOUND;
				end
			end
			bdl_pkg::S_TAKE: begin
				ctrl.cap_val = 1'b1;
				ctrl.ptr_sel = bdl_pkg::PTR_INC;
				ctrl.cnt_dec = flags.last;
			end
			bdl_pkg::S_SHDN: begin
				ctrl.wr_sel  = bdl_pkg::WR_DOWN;
				ctrl.ptr_sel = bdl_pkg::PTR_INC;
				ctrl.cnt_dec = flags.last;
			end
			bdl_pkg::S_SHUP: begin
				ctrl.wr_sel  = bdl_pkg::WR_UP;
				ctrl.rd_sel  = bdl_pkg::RD_PREV;
				ctrl.ptr_sel = bdl_pkg::PTR_DEC;
			end
			bdl_pkg::S_WR0: begin
				ctrl.wr_sel  = bdl_pkg::WR_FRONT;
				ctrl.cnt_inc = 1'b1;
			end
			bdl_pkg::S_PEEK: ctrl.cap_val = 1'b1;
			bdl_pkg::S_FIN:  ctrl.load_out = out_free;
			default: ctrl.rd_sel = bdl_pkg::RD_NEXT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bdl_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			req_q <= in_req;
	end

endmodule

`default_nettype wire

### hdl/bdl_dp.sv
`default_nettype none

module bdl_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  bdl_pkg::ctrl_t                   ctrl,
	input  bdl_pkg::req_t                    in_req,
	input  wire logic [bdl_pkg::VAL_W-1:0]   in_value,
	input  wire logic [bdl_pkg::POS_W-1:0]   in_position,
	output bdl_pkg::flags_t                  flags,
	output logic [bdl_pkg::VAL_W-1:0]        result_value,
	output logic [bdl_pkg::POS_W-1:0]        found_position,
	output logic [bdl_pkg::COUNT_W-1:0]      entry_count,
	output logic [bdl_pkg::STAT_W-1:0]       status
);

	logic [bdl_pkg::DATA_W-1:0] mem [bdl_pkg::DEPTH];
	logic [bdl_pkg::DATA_W-1:0] rd_q;
	logic [bdl_pkg::DATA_W-1:0] val_q;
	logic [bdl_pkg::DATA_W-1:0] in_data;
	logic [bdl_pkg::DATA_W-1:0] rv_q;
	logic [bdl_pkg::IDX_W-1:0]  fp_q;
	bdl_pkg::status_t           st_q;
	logic [bdl_pkg::IDX_W-1:0]  ptr_q;
	logic [bdl_pkg::CNT_W-1:0]  total_q;
	logic [bdl_pkg::IDX_W-1:0]  start_ptr;
	logic [bdl_pkg::IDX_W-1:0]  ptr_inc;
	logic [bdl_pkg::IDX_W-1:0]  ptr_dec;
	logic [bdl_pkg::IDX_W-1:0]  rd_addr;
	logic [bdl_pkg::IDX_W-1:0]  wr_addr;
	logic [bdl_pkg::DATA_W-1:0] wr_data;
	logic                       wr_en;

	logic [bdl_pkg::VAL_W-1:0]   res_value_q;
	logic [bdl_pkg::POS_W-1:0]   res_pos_q;
	logic [bdl_pkg::COUNT_W-1:0] res_count_q;
	logic [bdl_pkg::STAT_W-1:0]  res_status_q;

	assign in_data = in_value[bdl_pkg::DATA_W-1:0];
	assign ptr_inc = bdl_pkg::IDX_W'(ptr_q + 1'b1);
	assign ptr_dec = bdl_pkg::IDX_W'(ptr_q - 1'b1);

	always_comb begin
		case (in_req)
			bdl_pkg::REQ_INS_FRONT, bdl_pkg::REQ_RM_BACK:
				start_ptr = bdl_pkg::IDX_W'(total_q - 1'b1);
			bdl_pkg::REQ_RM_POS:
				start_ptr = bdl_pkg::IDX_W'(in_position);
			default:
				start_ptr = '0;
		endcase
	end

	always_comb begin
		case (ctrl.rd_sel)
			bdl_pkg::RD_START: rd_addr = start_ptr;
			bdl_pkg::RD_NEXT:  rd_addr = ptr_inc;
			bdl_pkg::RD_PREV:  rd_addr = ptr_dec;
			default:           rd_addr = start_ptr;
		endcase
	end

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = '0;
		wr_data = rd_q;
		case (ctrl.wr_sel)
			bdl_pkg::WR_BACK: begin
				wr_addr = bdl_pkg::IDX_W'(total_q);
				wr_data = in_data;
			end
			bdl_pkg::WR_DOWN:  wr_addr = ptr_dec;
			bdl_pkg::WR_UP:    wr_addr = ptr_inc;
			bdl_pkg::WR_FRONT: wr_data = val_q;
			default:           wr_en = 1'b0;
		endcase
	end

	assign flags.full     = (total_q == bdl_pkg::CNT_W'(bdl_pkg::DEPTH));
	assign flags.empty    = (total_q == '0);
	assign flags.pos_bad  = (bdl_pkg::CNT_W'(in_position) >= total_q);
	assign flags.hit      = (rd_q == val_q);
	assign flags.last     = ((bdl_pkg::CNT_W'(ptr_q) + bdl_pkg::CNT_W'(1)) >= total_q);
	assign flags.ptr_zero = (ptr_q == '0);

	// entry store
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (ctrl.cnt_inc) begin
			total_q <= total_q + 1'b1;
		end else if (ctrl.cnt_dec) begin
			total_q <= total_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.ptr_sel)
			bdl_pkg::PTR_START: ptr_q <= start_ptr;
			bdl_pkg::PTR_INC:   ptr_q <= ptr_inc;
			bdl_pkg::PTR_DEC:   ptr_q <= ptr_dec;
			default:            ptr_q <= ptr_q;
		endcase
		if (ctrl.start) begin
			val_q <= in_data;
			rv_q  <= '0;
			fp_q  <= '0;
			st_q  <= ctrl.st_we ? ctrl.st_code : bdl_pkg::ST_OK;
		end else begin
			if (ctrl.cap_val)
				rv_q <= rd_q;
			if (ctrl.cap_pos)
				fp_q <= ptr_q;
			if (ctrl.st_we)
				st_q <= ctrl.st_code;
		end
		if (ctrl.load_out) begin
			res_value_q  <= bdl_pkg::VAL_W'(rv_q);
			res_pos_q    <= bdl_pkg::POS_W'(fp_q);
			res_count_q  <= bdl_pkg::COUNT_W'(total_q);
			res_status_q <= st_q;
		end
	end

	assign result_value   = res_value_q;
	assign found_position = res_pos_q;
	assign entry_count    = res_count_q;
	assign status         = res_status_q;

endmodule

`default_nettype wire

### hdl/bounded_double_ended_list_top.sv
// insert back and failed requests go straight to finish, peek captures the front entry,
// insert front shifts every entry up and then writes the front, removal at front, back or
// a position takes the entry and shifts the entries behind it down, searches and removal by
// value scan the list (one entry per cycle) and removal by value then shifts the rest down
// one item at a time: a new item is taken once the previous result has left the sequencer
// async reset empties the list and clears the handshake; stored data stays undefined
`default_nettype none

module bounded_double_ended_list_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bdl_req_if.sink    req,
	bdl_rsp_if.source  rsp
);

	bdl_pkg::ctrl_t  ctrl;
	bdl_pkg::flags_t flags;
	bdl_pkg::req_t   in_req;

	assign in_req = bdl_pkg::req_t'(req.req_type);

	bdl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_req    (in_req),
		.out_ready (rsp.ready),
		.flags     (flags),
		.ctrl      (ctrl),
		.in_ready  (req.ready),
		.out_valid (rsp.valid)
	);

	bdl_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.in_req         (in_req),
		.in_value       (req.value),
		.in_position    (req.position),
		.flags          (flags),
		.result_value   (rsp.result_value),
		.found_position (rsp.found_position),
		.entry_count    (rsp.entry_count),
		.status         (rsp.status)
	);

endmodule

`default_nettype wire

### verif/tb_bounded_double_ended_list_top.sv
`timescale 1ns / 100ps

module tb_bounded_double_ended_list_top;
	import bdl_pkg::*;

	localparam int RANDOM_ITEMS = 1250;
	localparam int LONG_HOLD    = 300;
	localparam int TAIL_CYCLES  = 40;

	typedef struct {
		req_t           kind;
		logic [VAL_W-1:0] val;
		logic [POS_W-1:0] pos;
		bit             hold_for_replies;
	} list_req_t;

	typedef struct {
		logic [VAL_W-1:0]   value;
		logic [POS_W-1:0]   pos;
		logic [COUNT_W-1:0] count;
		status_t            status;
	} list_reply_t;

	typedef enum {RX_FREE, RX_CHOPPY, RX_SLUGGISH} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	bdl_req_if req_bus ();
	bdl_rsp_if rsp_bus ();

	bounded_double_ended_list_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	list_req_t   pending_reqs[$];
	list_reply_t expected_replies[$];
	logic [VAL_W-1:0] planned_list[$];

	logic [DATA_W-1:0] list_mem [DEPTH];
	int unsigned       list_len = 0;

	int mismatches = 0;
	int replies_checked = 0;

	list_req_t   drv_item;
	int          burst_left, gap_left, n_taken, n_answered;
	list_req_t   seen_item;
	list_reply_t want;
	rx_mode_t    rx_mode;
	int          rx_phase_left, rx_hold_left, rx_seen;
	bit          long_hold_done;

	always #2 clk = ~clk;

	task automatic note_mismatch(input string what, input int got, input int exp_val);
		mismatches++;
		$display("mismatch at reply %0d: %s got %0d, want %0d",
			replies_checked, what, got, exp_val);
	endtask

	function automatic logic [DATA_W-1:0] remove_entry(input int unsigned idx);
		logic [DATA_W-1:0] v;
		int unsigned i;
		v = list_mem[idx];
		for (i = idx; i + 1 < list_len; i++)
			list_mem[i] = list_mem[i + 1];
		list_len--;
		return v;
	endfunction

	function automatic list_reply_t predict_reply(input list_req_t it);
		list_reply_t r;
		int unsigned idx;
		r.value  = '0;
		r.pos    = '0;
		r.status = ST_OK;
		if (it.kind == REQ_INS_FRONT || it.kind == REQ_INS_BACK) begin
			if (list_len >= DEPTH) begin
				r.status = ST_FULL;
			end else if (it.kind == REQ_INS_FRONT) begin
				for (idx = list_len; idx > 0; idx--)
					list_mem[idx] = list_mem[idx - 1];
				list_mem[0] = it.val;
				list_len++;
			end else begin
				list_mem[list_len] = it.val;
				list_len++;
			end
		end else if (list_len == 0) begin
			r.status = (it.kind == REQ_SEARCH) ? ST_NOT_FOUND : ST_EMPTY;
		end else begin
			case (it.kind)
				REQ_RM_FRONT: r.value = remove_entry(0);
				REQ_RM_BACK:  r.value = remove_entry(list_len - 1);
				REQ_RM_POS: begin
					if (it.pos >= list_len)
						r.status = ST_BAD_POS;
					else
						r.value = remove_entry(it.pos);
				end
				REQ_RM_VALUE, REQ_SEARCH: begin
					for (idx = 0; idx < list_len; idx++)
						if (list_mem[idx] == it.val)
							break;
					if (idx >= list_len) begin
						r.status = ST_NOT_FOUND;
					end else begin
						r.pos = idx[POS_W-1:0];
						if (it.kind == REQ_RM_VALUE)
							r.value = remove_entry(idx);
					end
				end
				default: r.value = list_mem[0];
			endcase
		end
		r.count = list_len[COUNT_W-1:0];
		return r;
	endfunction

	// keeps a rough picture of the list so that random values and positions often hit
	task automatic plan_item(input req_t kind, input logic [VAL_W-1:0] val,
			input logic [POS_W-1:0] pos, input bit hold);
		list_req_t it;
		int idx;
		it.kind = kind;
		it.val = val;
		it.pos = pos;
		it.hold_for_replies = hold;
		pending_reqs.push_back(it);
		case (kind)
			REQ_INS_FRONT: if (planned_list.size() < DEPTH) planned_list.push_front(val);
			REQ_INS_BACK:  if (planned_list.size() < DEPTH) planned_list.push_back(val);
			REQ_RM_FRONT:  if (planned_list.size() != 0) void'(planned_list.pop_front());
			REQ_RM_BACK:   if (planned_list.size() != 0) void'(planned_list.pop_back());
			REQ_RM_POS:    if (pos < planned_list.size()) planned_list.delete(pos);
			REQ_RM_VALUE: begin
				for (idx = 0; idx < planned_list.size(); idx++)
					if (planned_list[idx] == val)
						break;
				if (idx < planned_list.size())
					planned_list.delete(idx);
			end
			default: ;
		endcase
	endtask

	task automatic plan_random(input int ins_pct, input bit hold);
		req_t kind;
		logic [VAL_W-1:0] val;
		logic [POS_W-1:0] pos;
		int n;
		n = planned_list.size();
		if ($urandom_range(0, 99) < ins_pct)
			kind = $urandom_range(0, 1) ? REQ_INS_FRONT : REQ_INS_BACK;
		else
			kind = req_t'($urandom_range(2, 7));
		case ($urandom_range(0, 9))
			0, 1, 2, 3: val = (n != 0) ? planned_list[$urandom_range(0, n - 1)] : VAL_W'($urandom);
			4, 5, 6: val = VAL_W'($urandom_range(0, 5));
			7: val = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: val = VAL_W'($urandom);
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5, 6: pos = (n != 0) ? POS_W'($urandom_range(0, n - 1)) : POS_W'($urandom);
			7: pos = POS_W'(n);
			default: pos = POS_W'($urandom);
		endcase
		plan_item(kind, val, pos, hold);
	endtask

	// sender: bursts and gaps, holds an item back until all replies are in when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			req_bus.req_type <= REQ_PEEK;
			req_bus.value <= '0;
			req_bus.position <= '0;
			burst_left = 0;
			gap_left = 0;
			n_taken = 0;
			n_answered = 0;
		end else begin
			if (req_bus.valid && req_bus.ready)
				n_taken++;
			if (rsp_bus.valid && rsp_bus.ready)
				n_answered++;
			if (!req_bus.valid || req_bus.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_bus.valid <= 1'b0;
				end else if (pending_reqs.size() != 0 &&
						(!pending_reqs[0].hold_for_replies || n_taken == n_answered)) begin
					drv_item = pending_reqs.pop_front();
					req_bus.valid <= 1'b1;
					req_bus.req_type <= drv_item.kind;
					req_bus.value <= drv_item.val;
					req_bus.position <= drv_item.pos;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 30);
						case ($urandom_range(0, 3))
							0: gap_left = 0;
							1: gap_left = $urandom_range(20, 40);
							default: gap_left = $urandom_range(1, 8);
						endcase
					end
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: changing stall pattern, one long hold-off to back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
			rx_mode = RX_FREE;
			rx_phase_left = 0;
			rx_hold_left = 0;
			rx_seen = 0;
			long_hold_done = 1'b0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready)
				rx_seen++;
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				rsp_bus.ready <= 1'b0;
			end else if (!long_hold_done && rx_seen >= 400) begin
				long_hold_done = 1'b1;
				rx_hold_left = LONG_HOLD;
				rsp_bus.ready <= 1'b0;
			end else begin
				if (rx_phase_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 2));
					rx_phase_left = $urandom_range(20, 120);
				end else begin
					rx_phase_left--;
				end
				case (rx_mode)
					RX_FREE:    rsp_bus.ready <= 1'b1;
					RX_CHOPPY:  rsp_bus.ready <= ($urandom_range(0, 3) != 0);
					default:    rsp_bus.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready) begin
				seen_item.kind = req_t'(req_bus.req_type);
				seen_item.val = req_bus.value;
				seen_item.pos = req_bus.position;
				seen_item.hold_for_replies = 1'b0;
				expected_replies.push_back(predict_reply(seen_item));
			end
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (expected_replies.size() == 0) begin
					note_mismatch("reply with none expected, status", rsp_bus.status, 0);
				end else begin
					want = expected_replies.pop_front();
					if (rsp_bus.result_value !== want.value)
						note_mismatch("result_value", rsp_bus.result_value, want.value);
					if (rsp_bus.found_position !== want.pos)
						note_mismatch("found_position", rsp_bus.found_position, want.pos);
					if (rsp_bus.entry_count !== want.count)
						note_mismatch("entry_count", rsp_bus.entry_count, want.count);
					if (rsp_bus.status !== want.status)
						note_mismatch("status", rsp_bus.status, want.status);
				end
				replies_checked++;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int i, k, ep_len, ins_pct;
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.req_type = REQ_PEEK;
		req_bus.value = '0;
		req_bus.position = '0;
		rsp_bus.ready = 1'b0;

		// empty list
		plan_item(REQ_PEEK, 8'h00, 4'h0, 1'b0);
		plan_item(REQ_RM_FRONT, 8'h00, 4'h0, 1'b0);
		plan_item(REQ_RM_BACK, 8'h00, 4'h0, 1'b0);
		plan_item(REQ_RM_POS, 8'h00, 4'h0, 1'b0);
		plan_item(REQ_RM_VALUE, 8'h00, 4'h0, 1'b0);
		plan_item(REQ_SEARCH, 8'hFF, 4'hF, 1'b0);
		// fill to the brim, with repeated values
		for (i = 0; i < DEPTH; i++)
			plan_item((i % 2) ? REQ_INS_BACK : REQ_INS_FRONT,
				(i == 0) ? 8'h00 : (i == 1) ? 8'hFF : (i % 4 == 2) ? 8'h3C : VAL_W'(i * 17),
				4'h0, 1'b0);
		plan_item(REQ_INS_BACK, 8'hAA, 4'h0, 1'b0);
		plan_item(REQ_RM_POS, 8'h00, 4'hF, 1'b0);
		plan_item(REQ_RM_POS, 8'h00, 4'hF, 1'b0);
		plan_item(REQ_RM_VALUE, 8'h3C, 4'h0, 1'b0);
		plan_item(REQ_SEARCH, 8'h3C, 4'h0, 1'b0);
		plan_item(REQ_SEARCH, 8'h81, 4'h0, 1'b0);

		// episodes that lean towards filling, draining or neither
		k = 0;
		while (k < RANDOM_ITEMS) begin
			ep_len = $urandom_range(10, 60);
			case ($urandom_range(0, 3))
				0: ins_pct = 80;
				1: ins_pct = 20;
				2: ins_pct = 45;
				default: ins_pct = 60;
			endcase
			for (i = 0; i < ep_len && k < RANDOM_ITEMS; i++) begin
				plan_random(ins_pct, k == 0 || k == 600 || $urandom_range(0, 149) == 0);
				k++;
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || req_bus.valid)
			@(negedge clk);
		while (expected_replies.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (expected_replies.size() != 0)
			note_mismatch("replies never arrived", 0, expected_replies.size());
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### bounded_double_ended_list_top.f
hdl/bdl_pkg.sv
hdl/bdl_if.sv
hdl/bdl_ctrl.sv
hdl/bdl_dp.sv
hdl/bounded_double_ended_list_top.sv
verif/tb_bounded_double_ended_list_top.sv
